// ===== src/bmp_pkg.sv =====
// types and constants shared by the bmp24 stream decoder
package bmp_pkg;

    localparam logic [5:0] HEADER_BYTES  = 6'd54;
    localparam logic [5:0] WIDTH_LO_POS  = 6'd18;
    localparam logic [5:0] WIDTH_HI_POS  = 6'd19;
    localparam logic [5:0] HEIGHT_LO_POS = 6'd22;
    localparam logic [5:0] HEIGHT_HI_POS = 6'd23;

    localparam logic [7:0] RED_MASK   = 8'hF8;
    localparam logic [7:0] GREEN_MASK = 8'hFC;

    localparam logic [1:0] PHASE_BLUE  = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_RED   = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        logic [15:0] color565;
        logic [14:0] column;
        logic [14:0] row;
        logic        last_pixel;
    } pixel_t;

    function automatic logic dim_bad(input logic [15:0] d);
        return (d == 16'd0) || d[15];
    endfunction

endpackage

// ===== src/bmp_in_reg.sv =====
// input register stage holding one accepted byte beat
module bmp_in_reg
    import bmp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // room when empty or when the held beat moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tvalid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/bmp_decode.sv =====
// header parse, pixel gathering and coordinate state for one byte per cycle while advance is high
module bmp_decode
    import bmp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  in_item_t item,
    output logic     res_valid,
    output pixel_t   res
);

    logic [5:0]  hp_reg,    hp_next;
    logic [15:0] w_reg,     w_next;
    logic [15:0] h_reg,     h_next;
    logic [14:0] col_reg,   col_next;
    logic [14:0] rowc_reg,  rowc_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  blue_reg,  blue_next;
    logic [7:0]  green_reg, green_next;
    logic [1:0]  pad_reg,   pad_next;
    logic        done_reg,  done_next;

    always_comb
    begin
        hp_next    = hp_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        col_next   = col_reg;
        rowc_next  = rowc_reg;
        phase_next = phase_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        pad_next   = pad_reg;
        done_next  = done_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (item.file_start)
        begin
            hp_next    = 6'd0;
            w_next     = 16'd0;
            h_next     = 16'd0;
            col_next   = 15'd0;
            rowc_next  = 15'd0;
            phase_next = PHASE_BLUE;
            blue_next  = 8'd0;
            green_next = 8'd0;
            pad_next   = 2'd0;
            done_next  = 1'b0;
        end

        if (!done_next)
        begin
            if (hp_next != HEADER_BYTES)
            begin
                case (hp_next)
                    WIDTH_LO_POS:  w_next[7:0]  = item.byte_value;
                    WIDTH_HI_POS:  w_next[15:8] = item.byte_value;
                    HEIGHT_LO_POS: h_next[7:0]  = item.byte_value;
                    HEIGHT_HI_POS: h_next[15:8] = item.byte_value;
                    default:       ;
                endcase
                hp_next = hp_next + 6'd1;
                if (hp_next == HEADER_BYTES && (dim_bad(w_next) || dim_bad(h_next)))
                begin
                    done_next = 1'b1;
                end
            end
            else if (pad_next != 2'd0)
            begin
                pad_next = pad_next - 2'd1;
            end
            else
            begin
                case (phase_next)
                    PHASE_BLUE:
                    begin
                        blue_next  = item.byte_value;
                        phase_next = PHASE_GREEN;
                    end
                    PHASE_GREEN:
                    begin
                        green_next = item.byte_value;
                        phase_next = PHASE_RED;
                    end
                    default:
                    begin
                        phase_next   = PHASE_BLUE;
                        res_valid    = 1'b1;
                        res.color565 = {item.byte_value & RED_MASK, 8'd0}
                                     | {5'd0, green_next & GREEN_MASK, 3'd0}
                                     | {11'd0, blue_next[7:3]};
                        res.column   = col_next;
                        res.row      = h_next[14:0] - rowc_next - 15'd1;
                        col_next     = col_next + 15'd1;
                        if ({1'b0, col_next} == w_next)
                        begin
                            col_next  = 15'd0;
                            rowc_next = rowc_next + 15'd1;
                            pad_next  = w_next[1:0];
                            if ({1'b0, rowc_next} == h_next)
                            begin
                                res.last_pixel = 1'b1;
                                done_next      = 1'b1;
                                pad_next       = 2'd0;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg    <= 6'd0;
            w_reg     <= 16'd0;
            h_reg     <= 16'd0;
            col_reg   <= 15'd0;
            rowc_reg  <= 15'd0;
            phase_reg <= PHASE_BLUE;
            blue_reg  <= 8'd0;
            green_reg <= 8'd0;
            pad_reg   <= 2'd0;
            done_reg  <= 1'b1;
        end
        else if (advance)
        begin
            hp_reg    <= hp_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            col_reg   <= col_next;
            rowc_reg  <= rowc_next;
            phase_reg <= phase_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            pad_reg   <= pad_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== src/bmp_out_reg.sv =====
// result register holding one pixel beat for the master side
module bmp_out_reg
    import bmp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    input  logic   res_valid,
    input  pixel_t res,
    output logic   advance,
    output logic   m_tvalid,
    input  logic   m_tready,
    output pixel_t m_pixel
);

    logic   valid_reg;
    logic   valid_next;
    pixel_t pixel_reg;

    // a held byte may be worked on when the result slot is free or draining
    assign advance = item_valid && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg && !m_tready;
        if (advance)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            pixel_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_pixel  = pixel_reg;

endmodule

// ===== src/bmp24_stream_to_rgb565.sv =====
// top level: 24-bit bmp byte stream to rgb565 pixel stream
// a red byte passes the input register; its pixel beat then waits in the result register
// throughput: one byte beat per cycle while m_tready is high, set by the combinational decode
//   between the input register and the result register; one pixel per three image bytes
// reset: handshake registers empty, decoder idle until a beat with file_start,
//   bytes before that are dropped
module bmp24_stream_to_rgb565
    import bmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value [7:0]
    input  logic        s_tuser,   // file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // color565 [15:0], column [30:16], row [45:31], zero fill
    output logic        m_tlast    // last_pixel
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     res_valid;
    pixel_t   res;
    pixel_t   m_pixel;

    assign s_item.byte_value = s_tdata;
    assign s_item.file_start = s_tuser;

    // input register: takes a new beat when empty or whenever the held one moves on
    bmp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // header count, dimension capture, row padding skip, pixel gathering and row flip
    bmp_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register: parts the decode from master-side stalls
    bmp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res_valid  (res_valid),
        .res        (res),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_pixel    (m_pixel)
    );

    assign m_tdata = {2'b00, m_pixel.row, m_pixel.column, m_pixel.color565};
    assign m_tlast = m_pixel.last_pixel;

endmodule
